FILE: rtl/signed_divide_remainder_64_top_assert.svh
// Assertion macros for the signed 64-bit divider.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SIGNED_DIVIDE_REMAINDER_64_TOP_ASSERT_SVH
`define SIGNED_DIVIDE_REMAINDER_64_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("divider assertion failed");
// next-cycle implication
`define SDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("divider assertion failed");
`else
`define SDR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sdr_pkg.sv
// Shared types and constants of the signed 64-bit divider.
// No dependencies; used by sdr_cell and signed_divide_remainder_64_top.
package sdr_pkg;

	localparam int WORD_BITS      = 64;
	localparam int DIGIT_BITS_DEF = 16;
	localparam int CNT_BITS       = $clog2(WORD_BITS);
	localparam logic [WORD_BITS-1:0] SIGN_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [WORD_BITS-1:0] dividend;
		logic signed [WORD_BITS-1:0] divisor;
	} in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] quotient;
		logic signed [WORD_BITS-1:0] remainder;
		logic                        divide_by_zero;
	} out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic qbit;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FIN
	} state_t;

	function automatic logic [WORD_BITS-1:0] magnitude(input logic [WORD_BITS-1:0] x);
		return x[WORD_BITS-1] ? (~x + WORD_BITS'(1)) : x;
	endfunction

	function automatic logic [WORD_BITS-1:0] negate_if(input logic [WORD_BITS-1:0] x,
	                                                   input logic neg);
		return neg ? (~x + WORD_BITS'(1)) : x;
	endfunction

endpackage

FILE: rtl/sdr_cell.sv
// One digit slice of the restoring divider: partial remainder, dividend/quotient
// shift bits and divisor digit. Depends on sdr_pkg for the control struct.
module sdr_cell #(
	parameter int DIGIT_BITS = sdr_pkg::DIGIT_BITS_DEF
) (
	input  logic                  clk,
	input  sdr_pkg::cell_ctl_t    ctl,
	input  logic [DIGIT_BITS-1:0] den_load,
	input  logic [DIGIT_BITS-1:0] num_load,
	input  logic                  rem_in,
	input  logic                  num_in,
	input  logic                  borrow_in,
	output logic                  rem_msb,
	output logic                  num_msb,
	output logic                  borrow_out,
	output logic [DIGIT_BITS-1:0] rem,
	output logic [DIGIT_BITS-1:0] num
);

	logic [DIGIT_BITS-1:0] rem_q;
	logic [DIGIT_BITS-1:0] num_q;
	logic [DIGIT_BITS-1:0] den_q;
	logic [DIGIT_BITS-1:0] shifted;
	logic [DIGIT_BITS:0]   sub;

	assign shifted = {rem_q[DIGIT_BITS-2:0], rem_in};
	// top bit of the widened difference is the borrow to the next cell
	assign sub = {1'b0, shifted} - {1'b0, den_q} - (DIGIT_BITS+1)'(borrow_in);

	assign borrow_out = sub[DIGIT_BITS];
	assign rem_msb    = rem_q[DIGIT_BITS-1];
	assign num_msb    = num_q[DIGIT_BITS-1];
	assign rem        = rem_q;
	assign num        = num_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			num_q <= num_load;
			den_q <= den_load;
		end else if (ctl.step) begin
			// keep the difference only when the whole subtract did not go negative
			rem_q <= ctl.qbit ? sub[DIGIT_BITS-1:0] : shifted;
			num_q <= {num_q[DIGIT_BITS-2:0], num_in};
		end
	end

endmodule

FILE: rtl/signed_divide_remainder_64_top.sv
// Signed 64-bit divide with remainder, one quotient bit per cycle.
// The start beat is taken in S_IDLE; S_RUN runs 64 shift-subtract steps through the
// cell row, S_FIN fixes the signs, done strobes as S_FIN is left. Busy drops with
// the strobe; no beat is taken before it. The ripple borrow sets the clock period.
// arst_n clears the sequencer and the strobe; the receiver cannot stall.
`include "signed_divide_remainder_64_top_assert.svh"
module signed_divide_remainder_64_top #(
	parameter int DIGIT_BITS = sdr_pkg::DIGIT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sdr_pkg::in_t  operands,
	output logic          busy,
	output logic          done,
	output sdr_pkg::out_t result
);

	localparam int WB    = sdr_pkg::WORD_BITS;
	localparam int CELLS = (WB + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int W     = CELLS * DIGIT_BITS;
	localparam logic [sdr_pkg::CNT_BITS-1:0] LAST = sdr_pkg::CNT_BITS'(WB - 1);

	sdr_pkg::state_t    state_q, state_d;
	sdr_pkg::cell_ctl_t ctl;
	logic [sdr_pkg::CNT_BITS-1:0] cnt_q;

	logic          neg_quo_q;
	logic          neg_rem_q;
	logic          dz_q;
	logic [WB-1:0] dividend_q;
	sdr_pkg::out_t result_q;
	logic          done_q;

	logic [W-1:0]     den_wide;
	logic [W-1:0]     num_wide;
	logic [W-1:0]     rem_all;
	logic [W-1:0]     num_all;
	logic [CELLS:0]   borrow;
	logic [CELLS-1:0] rem_msb;
	logic [CELLS-1:0] num_msb;
	logic             accept;

	assign accept   = start && !busy;
	assign den_wide = W'(sdr_pkg::magnitude(operands.divisor));
	// dividend sits at the top of the row so its msb leaves first
	assign num_wide = W'(sdr_pkg::magnitude(operands.dividend)) << (W - WB);
	assign borrow[0] = 1'b0;

	for (genvar i = 0; i < CELLS; i++) begin : g_row
		logic rem_in_w;
		logic num_in_w;
		if (i == 0) begin : g_first
			assign rem_in_w = num_msb[CELLS-1];
			assign num_in_w = ctl.qbit;
		end else begin : g_next
			assign rem_in_w = rem_msb[i-1];
			assign num_in_w = num_msb[i-1];
		end
		sdr_cell #(
			.DIGIT_BITS(DIGIT_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.den_load  (den_wide[i*DIGIT_BITS +: DIGIT_BITS]),
			.num_load  (num_wide[i*DIGIT_BITS +: DIGIT_BITS]),
			.rem_in    (rem_in_w),
			.num_in    (num_in_w),
			.borrow_in (borrow[i]),
			.rem_msb   (rem_msb[i]),
			.num_msb   (num_msb[i]),
			.borrow_out(borrow[i+1]),
			.rem       (rem_all[i*DIGIT_BITS +: DIGIT_BITS]),
			.num       (num_all[i*DIGIT_BITS +: DIGIT_BITS])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdr_pkg::S_IDLE: begin
				if (start) state_d = sdr_pkg::S_RUN;
			end
			sdr_pkg::S_RUN: begin
				if (cnt_q == LAST) state_d = sdr_pkg::S_FIN;
			end
			sdr_pkg::S_FIN: begin
				state_d = sdr_pkg::S_IDLE;
			end
			default: begin
				state_d = sdr_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		ctl.load = 1'b0;
		ctl.step = 1'b0;
		ctl.qbit = !borrow[CELLS];
		unique case (state_q)
			sdr_pkg::S_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			sdr_pkg::S_RUN: begin
				ctl.step = 1'b1;
			end
			sdr_pkg::S_FIN: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdr_pkg::S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == sdr_pkg::S_FIN);
			if (accept) cnt_q <= '0;
			else if (state_q == sdr_pkg::S_RUN) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_quo_q  <= operands.dividend[WB-1] ^ operands.divisor[WB-1];
			neg_rem_q  <= operands.dividend[WB-1];
			dz_q       <= (operands.divisor == '0);
			dividend_q <= operands.dividend;
		end
		if (state_q == sdr_pkg::S_FIN) begin
			// zero divisor overrides whatever the row produced
			if (dz_q) begin
				result_q.quotient  <= '0;
				result_q.remainder <= dividend_q;
			end else begin
				result_q.quotient  <= sdr_pkg::negate_if(num_all[WB-1:0], neg_quo_q);
				result_q.remainder <= sdr_pkg::negate_if(rem_all[WB-1:0], neg_rem_q);
			end
			result_q.divide_by_zero <= dz_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`SDR_ASSERT_NEXT(a_accept_runs, clk, arst_n, start && !busy, state_q == sdr_pkg::S_RUN)
	`SDR_ASSERT_IMPL(a_done_after_fin, clk, arst_n, done_q, $past(state_q == sdr_pkg::S_FIN))
	`SDR_ASSERT_NEXT(a_run_length, clk, arst_n, (state_q == sdr_pkg::S_RUN) && (cnt_q != LAST), state_q == sdr_pkg::S_RUN)
	`SDR_ASSERT_IMPL(a_dz_zero_quo, clk, arst_n, done_q && result_q.divide_by_zero, result_q.quotient == '0)

endmodule
